>>> hdl/r16dec_pkg.sv
// package for the 16-bit risc instruction decoder
// holds operand mode and operation codes plus the operand decode helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package r16dec_pkg;

    // operand addressing modes
    localparam logic [3:0] MODE_NONE      = 4'd0;
    localparam logic [3:0] MODE_REGISTER  = 4'd1;
    localparam logic [3:0] MODE_BASE_DISP = 4'd2;
    localparam logic [3:0] MODE_PC_REL    = 4'd3;
    localparam logic [3:0] MODE_ABS_ADDR  = 4'd4;
    localparam logic [3:0] MODE_INDIRECT  = 4'd5;
    localparam logic [3:0] MODE_AUTOINC   = 4'd6;
    localparam logic [3:0] MODE_IMMED     = 4'd7;
    localparam logic [3:0] MODE_JUMP      = 4'd8;

    // single-operand selector codes that need special handling
    localparam logic [2:0] SEL_SWPB    = 3'd1;
    localparam logic [2:0] SEL_SXT     = 3'd3;
    localparam logic [2:0] SEL_CALL    = 3'd5;
    localparam logic [2:0] SEL_RETI    = 3'd6;
    localparam logic [2:0] SEL_INVALID = 3'd7;

    // operation code bases
    localparam logic [4:0] OP_MOV_BASE  = 5'd7;
    localparam logic [4:0] OP_JUMP_BASE = 5'd19;

    // addressing register numbers with special meaning
    localparam logic [3:0] RNUM_PC = 4'd0;
    localparam logic [3:0] RNUM_SR = 4'd2;
    localparam logic [3:0] RNUM_CG = 4'd3;

    // as field codes
    localparam logic [1:0] AS_DIRECT   = 2'd0;
    localparam logic [1:0] AS_INDEXED  = 2'd1;
    localparam logic [1:0] AS_INDIRECT = 2'd2;
    localparam logic [1:0] AS_AUTOINC  = 2'd3;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  rnum;
        logic [15:0] value;
        logic        ext;
    } opnd_dec_t;

    // source operand decode, value holds the generated constant
    function automatic opnd_dec_t src_decode(input logic [1:0] as_f, input logic [3:0] r);
        opnd_dec_t d;
        d = '{mode: MODE_NONE, rnum: 4'd0, value: 16'd0, ext: 1'b0};
        case (as_f)
            AS_DIRECT: begin
                if (r == RNUM_CG) begin
                    d.mode = MODE_IMMED;
                end else begin
                    d.mode = MODE_REGISTER;
                    d.rnum = r;
                end
            end
            AS_INDEXED: begin
                if (r == RNUM_PC) begin
                    d.mode = MODE_PC_REL;
                    d.ext  = 1'b1;
                end else if (r == RNUM_SR) begin
                    d.mode = MODE_ABS_ADDR;
                    d.ext  = 1'b1;
                end else if (r == RNUM_CG) begin
                    d.mode  = MODE_IMMED;
                    d.value = 16'h0001;
                end else begin
                    d.mode = MODE_BASE_DISP;
                    d.rnum = r;
                    d.ext  = 1'b1;
                end
            end
            AS_INDIRECT: begin
                if (r == RNUM_SR) begin
                    d.mode  = MODE_IMMED;
                    d.value = 16'h0004;
                end else if (r == RNUM_CG) begin
                    d.mode  = MODE_IMMED;
                    d.value = 16'h0002;
                end else begin
                    d.mode = MODE_INDIRECT;
                    d.rnum = r;
                end
            end
            default: begin
                if (r == RNUM_PC) begin
                    d.mode = MODE_IMMED;
                    d.ext  = 1'b1;
                end else if (r == RNUM_SR) begin
                    d.mode  = MODE_IMMED;
                    d.value = 16'h0008;
                end else if (r == RNUM_CG) begin
                    d.mode  = MODE_IMMED;
                    d.value = 16'hFFFF;
                end else begin
                    d.mode = MODE_AUTOINC;
                    d.rnum = r;
                end
            end
        endcase
        return d;
    endfunction

    // destination operand decode, value is never set here; ext flags an extension word
    function automatic opnd_dec_t dst_decode(input logic ad, input logic [3:0] r);
        opnd_dec_t d;
        d = '{mode: MODE_NONE, rnum: 4'd0, value: 16'd0, ext: 1'b0};
        if (!ad) begin
            d.mode = MODE_REGISTER;
            d.rnum = r;
        end else if (r == RNUM_PC) begin
            d.mode = MODE_PC_REL;
            d.ext  = 1'b1;
        end else if (r == RNUM_SR) begin
            d.mode = MODE_ABS_ADDR;
            d.ext  = 1'b1;
        end else begin
            d.mode = MODE_BASE_DISP;
            d.rnum = r;
            d.ext  = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hdl/risc16_instruction_decoder_top.sv
// top level of the 16-bit risc instruction decoder
// input register, single-pass decode logic, result register
// depends on r16dec_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
// - s_ channel carries one instruction window per item: up to three words
//   and a count of words present (saturated at three)
// - m_ channel returns one decoded item per input item, in order
// - an item that is illegal or truncated comes back with every field zero
// - an accepted item is held in the input register, and its decoded result is
//   then registered in the result register and driven on m_
// - throughput: one item per cycle while m_tready is high, set by the two-stage register pipeline;
//   the decode itself is a single pass of narrow muxing between the registers
// - when the receiver stalls, the result register holds and the input register
//   keeps its item; s_tready drops once both stages are full and m_tready is low
// - reset (aresetn low at an edge) empties both stages; payload registers are not reset
module risc16_instruction_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // first_word[15:0], second_word[31:16], third_word[47:32],
    // words_available[49:48], zero fill [55:50]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // length_bytes[2:0], operation[7:3], byte_size[8], operand_count[10:9],
    // first_mode[14:11], first_register[18:15], first_value[34:19],
    // second_mode[37:35], second_register[41:38], second_value[57:42],
    // zero fill [63:58]
    output logic [63:0]      m_tdata
);

    // input stage
    logic        in_vld_reg;
    logic [15:0] w0_reg;
    logic [15:0] w1_reg;
    logic [15:0] w2_reg;
    logic [1:0]  avail_reg;

    // result stage
    logic        out_vld_reg;
    logic [63:0] out_data_reg;

    logic out_adv;
    logic in_take;

    // result stage frees up when empty or when its item leaves this cycle
    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_adv;
    assign in_take  = s_tvalid && s_tready;

    // decode signals
    r16dec_pkg::opnd_dec_t src_d;
    r16dec_pkg::opnd_dec_t dst_d;
    logic [2:0]  sel;
    logic [1:0]  used;
    logic        legal;
    logic [15:0] jmp_off;

    logic [2:0]  length_bytes;
    logic [4:0]  operation;
    logic        byte_size;
    logic [1:0]  operand_count;
    logic [3:0]  first_mode;
    logic [3:0]  first_register;
    logic [15:0] first_value;
    logic [2:0]  second_mode;
    logic [3:0]  second_register;
    logic [15:0] second_value;
    logic [63:0] out_data_next;

    assign sel     = w0_reg[9:7];
    assign src_d   = r16dec_pkg::src_decode(w0_reg[5:4],
                         (w0_reg[15:14] != 2'b00) ? w0_reg[11:8] : w0_reg[3:0]);
    assign dst_d   = r16dec_pkg::dst_decode(w0_reg[7], w0_reg[3:0]);
    // sign-extend the 10-bit offset, double it and add 2
    assign jmp_off = {{5{w0_reg[9]}}, w0_reg[9:0], 1'b0} + 16'd2;

    always_comb begin
        legal           = 1'b0;
        used            = 2'd1;
        operation       = 5'd0;
        byte_size       = 1'b0;
        operand_count   = 2'd0;
        first_mode      = r16dec_pkg::MODE_NONE;
        first_register  = 4'd0;
        first_value     = 16'd0;
        second_mode     = 3'(r16dec_pkg::MODE_NONE);
        second_register = 4'd0;
        second_value    = 16'd0;

        if (w0_reg[15:11] == 5'b00010) begin
            // single-operand format
            byte_size = w0_reg[6];
            operation = {2'b00, sel};
            if (sel == r16dec_pkg::SEL_INVALID) begin
                legal = 1'b0;
            end else if ((sel == r16dec_pkg::SEL_SWPB || sel == r16dec_pkg::SEL_SXT
                          || sel == r16dec_pkg::SEL_CALL) && w0_reg[6]) begin
                legal = 1'b0;
            end else if (sel == r16dec_pkg::SEL_RETI) begin
                // reti takes no size, mode or register bits
                legal = (w0_reg[6:0] == 7'd0);
            end else begin
                legal          = 1'b1;
                operand_count  = 2'd1;
                first_mode     = src_d.mode;
                first_register = src_d.rnum;
                first_value    = src_d.ext ? w1_reg : src_d.value;
                used           = src_d.ext ? 2'd2 : 2'd1;
            end
        end else if (w0_reg[15:14] != 2'b00) begin
            // two-operand format, source extension word comes first
            legal           = 1'b1;
            byte_size       = w0_reg[6];
            operation       = {1'b0, w0_reg[15:12]} - 5'd4 + r16dec_pkg::OP_MOV_BASE;
            operand_count   = 2'd2;
            first_mode      = src_d.mode;
            first_register  = src_d.rnum;
            first_value     = src_d.ext ? w1_reg : src_d.value;
            second_mode     = dst_d.mode[2:0];
            second_register = dst_d.rnum;
            if (dst_d.ext) begin
                second_value = src_d.ext ? w2_reg : w1_reg;
            end
            used = 2'd1 + {1'b0, src_d.ext} + {1'b0, dst_d.ext};
        end else if (w0_reg[15:13] == 3'b001) begin
            // jump format
            legal         = 1'b1;
            operation     = r16dec_pkg::OP_JUMP_BASE + {2'b00, w0_reg[12:10]};
            operand_count = 2'd1;
            first_mode    = r16dec_pkg::MODE_JUMP;
            first_value   = jmp_off;
        end

        // too few words present, or illegal encoding: everything reads zero
        if (!legal || used > avail_reg || avail_reg == 2'd0) begin
            length_bytes = 3'd0;
            out_data_next = 64'd0;
        end else begin
            length_bytes  = {used, 1'b0};
            out_data_next = {6'd0, second_value, second_register, second_mode,
                             first_value, first_register, first_mode,
                             operand_count, byte_size, operation, length_bytes};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_adv) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            w0_reg    <= s_tdata[15:0];
            w1_reg    <= s_tdata[31:16];
            w2_reg    <= s_tdata[47:32];
            avail_reg <= s_tdata[49:48];
        end
        if (out_adv && in_vld_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
